@@ src/perceptron_branch_predictor_top_macros.svh @@
// Assertion helpers shared by the predictor RTL.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_TOP_MACROS_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pbp_pkg.sv @@
`default_nettype none
package pbp_pkg;

  localparam int TABLE_INDEX_BITS  = 7;
  localparam int WEIGHT_COUNT_BITS = 5;
  localparam int WEIGHT_MAG_BITS   = 7;

  localparam int ROWS   = 2 ** TABLE_INDEX_BITS;
  localparam int NW     = 2 ** WEIGHT_COUNT_BITS;
  localparam int W_W    = WEIGHT_MAG_BITS + 1;
  localparam int HIST_W = NW - 1;
  localparam int SUM_W  = WEIGHT_COUNT_BITS + WEIGHT_MAG_BITS + 1;

  localparam int LANES = (NW >= 8) ? 8 : NW;
  localparam int NGRP  = NW / LANES;

  localparam int THR_W     = 13;
  localparam int THR_RESET = 74;
  localparam int WSUM_W    = 13;

  localparam int PC_W        = 32;
  localparam int OUTCOME_BIT = PC_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = REG_IDX_W'(0);

  typedef logic signed [W_W-1:0] weight_t;
  typedef weight_t [NW-1:0] row_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic load;
    logic update;
    logic out_load;
  } cmd_t;

endpackage
`default_nettype wire

@@ src/pbp_regs.sv @@
`default_nettype none
module pbp_regs (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_psel,
  input  wire                            cfg_penable,
  input  wire                            cfg_pwrite,
  input  wire  [pbp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire  [pbp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pbp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output logic [pbp_pkg::THR_W-1:0]      thr
);
  import pbp_pkg::*;

  logic [THR_W-1:0]     thr_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign thr        = thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(THR_RESET);
    end else if (wr_en && (reg_idx == REG_THRESHOLD)) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx == REG_THRESHOLD) begin
      cfg_prdata = CFG_DATA_W'(thr_r);
    end else begin
      cfg_prdata = '0;
    end
  end

endmodule
`default_nettype wire

@@ src/pbp_ctrl.sv @@
`default_nettype none
`include "perceptron_branch_predictor_top_macros.svh"
module pbp_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire           out_tready,
  output pbp_pkg::cmd_t cmd
);
  import pbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SUM1,
    S_SUM2,
    S_UPD,
    S_DONE
  } state_t;

  state_t st_r;
  state_t st_nxt;
  logic   out_tvalid_r;
  logic   out_tvalid_nxt;

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    st_nxt         = st_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          st_nxt   = S_RD;
        end
      end
      S_RD:   st_nxt = S_SUM1;
      S_SUM1: st_nxt = S_SUM2;
      S_SUM2: st_nxt = S_UPD;
      S_UPD: begin
        cmd.update = 1'b1;
        st_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          st_nxt         = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  `PBP_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "busy accept")
  `PBP_ASSERT_NOW(a_out_from_done, clk, rst_n, $rose(out_tvalid_r), $past(st_r) == S_DONE, "out early")
  `PBP_ASSERT_NEXT(a_upd_once, clk, rst_n, cmd.update, !cmd.update && (st_r == S_DONE), "no done")

endmodule
`default_nettype wire

@@ src/pbp_datapath.sv @@
`default_nettype none
`include "perceptron_branch_predictor_top_macros.svh"
module pbp_datapath (
  input  wire                             clk,
  input  wire                             rst_n,
  input  pbp_pkg::cmd_t                   cmd,
  input  wire                             in_tuser,
  input  wire  [pbp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire  [pbp_pkg::THR_W-1:0]       thr,
  output logic [pbp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pbp_pkg::*;

  localparam int CMP_W = ((SUM_W > THR_W) ? SUM_W : THR_W) + 1;
  localparam int XW    = ((SUM_W > WSUM_W) ? SUM_W : WSUM_W) + 1;
  localparam weight_t W_MAX = weight_t'(2 ** WEIGHT_MAG_BITS - 1);
  localparam weight_t W_MIN = weight_t'(-(2 ** WEIGHT_MAG_BITS));
  localparam logic signed [XW-1:0] WSUM_MAX = XW'(2 ** (WSUM_W - 1) - 1);
  localparam logic signed [XW-1:0] WSUM_MIN = XW'(-(2 ** (WSUM_W - 1)));

  row_t                        mem [ROWS];
  logic [ROWS-1:0]             row_vld_r;
  logic [TABLE_INDEX_BITS-1:0] row_r;
  logic                        kind_r;
  logic                        outcome_r;
  logic [HIST_W-1:0]           hist_r;
  row_t                        rd_row_r;
  logic                        rd_vld_r;
  sum_t                        part_r [NGRP];
  sum_t                        part_nxt [NGRP];
  sum_t                        sum_r;
  sum_t                        sum_nxt;
  logic                        pred_r;
  logic [WSUM_W-1:0]           wsum_r;
  logic                        upd_r;
  logic [OUT_TDATA_W-1:0]      out_tdata_r;

  logic [NW-1:0]          hist_ext;
  row_t                   w_eff;
  row_t                   new_row;
  sum_t                   term [NW];
  logic                   pred;
  logic [SUM_W-1:0]       mag;
  logic                   wr_en;
  logic signed [XW-1:0]   sum_x;
  logic [WSUM_W-1:0]      wsum;

  function automatic weight_t nudge(input weight_t w, input logic up);
    weight_t r;
    if (up) begin
      r = (w == W_MAX) ? w : weight_t'(w + weight_t'(1));
    end else begin
      r = (w == W_MIN) ? w : weight_t'(w - weight_t'(1));
    end
    return r;
  endfunction

  assign hist_ext = {hist_r, 1'b1};

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      w_eff[i]   = rd_vld_r ? rd_row_r[i] : weight_t'(0);
      term[i]    = hist_ext[i] ? SUM_W'(w_eff[i]) : sum_t'(-SUM_W'(w_eff[i]));
      new_row[i] = nudge(w_eff[i], hist_ext[i] == outcome_r);
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_nxt[g] = '0;
      for (int l = 0; l < LANES; l++) begin
        part_nxt[g] = part_nxt[g] + term[g * LANES + l];
      end
    end
    sum_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum_nxt = sum_nxt + part_r[g];
    end
  end

  assign pred  = !sum_r[SUM_W-1];
  assign mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign wr_en = cmd.update && kind_r &&
                 ((pred != outcome_r) || (CMP_W'(mag) <= CMP_W'(thr)));
  assign sum_x = XW'(sum_r);

  always_comb begin
    if (sum_x > WSUM_MAX) begin
      wsum = WSUM_MAX[WSUM_W-1:0];
    end else if (sum_x < WSUM_MIN) begin
      wsum = WSUM_MIN[WSUM_W-1:0];
    end else begin
      wsum = sum_x[WSUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[row_r] <= new_row;
    end
    rd_row_r <= mem[row_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      hist_r    <= '0;
    end else if (cmd.update) begin
      if (wr_en) begin
        row_vld_r[row_r] <= 1'b1;
      end
      if (kind_r) begin
        hist_r <= HIST_W'({hist_r, outcome_r});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_tuser;
      row_r     <= in_tdata[TABLE_INDEX_BITS-1:0];
      outcome_r <= in_tdata[OUTCOME_BIT];
    end
    rd_vld_r <= row_vld_r[row_r];
    part_r   <= part_nxt;
    sum_r    <= sum_nxt;
    if (cmd.update) begin
      pred_r <= pred;
      wsum_r <= wsum;
      upd_r  <= wr_en;
    end
    if (cmd.out_load) begin
      out_tdata_r <= OUT_TDATA_W'({upd_r, wsum_r, pred_r});
    end
  end

  assign out_tdata = out_tdata_r;

  `PBP_ASSERT_NOW(a_wr_needs_train, clk, rst_n, wr_en, kind_r && cmd.update, "predict wrote row")
  `PBP_ASSERT_NEXT(a_hist_hold, clk, rst_n, !(cmd.update && kind_r), $stable(hist_r), "history moved")
  `PBP_ASSERT_NEXT(a_row_valid, clk, rst_n, wr_en, row_vld_r[$past(row_r)], "row not marked valid")

endmodule
`default_nettype wire

@@ src/perceptron_branch_predictor_top.sv @@
// Flow: from the input transfer to out_tvalid a request passes the read, two adder-tree stages,
// update and output load; the row read and write-back share one memory port.
// Occupancy: one request in flight; in_tready returns only once its result has been loaded.
// Reset: rst_n synchronous, active low; clears history, row valid bits and control,
// and sets training_threshold to 74. Cleared rows read as zero weights.
`default_nettype none
module perceptron_branch_predictor_top (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [pbp_pkg::IN_TDATA_W-1:0]  in_tdata,   // pc[31:0], outcome[32], zero[39:33]
  input  wire                             in_tuser,   // kind[0]
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [pbp_pkg::OUT_TDATA_W-1:0] out_tdata,  // prediction[0], weighted_sum[13:1],
                                                      // weights_updated[14], zero[15]
  input  wire                             cfg_psel,
  input  wire                             cfg_penable,
  input  wire                             cfg_pwrite,
  input  wire  [pbp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [pbp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [pbp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import pbp_pkg::*;

  cmd_t             cmd;
  logic [THR_W-1:0] thr;

  pbp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  pbp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pbp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .thr       (thr),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire
